>>> rtl/cldu_pkg.sv
// ----------------------------------------------------------------------------
// cldu_pkg
// Shared types and constants for the cursor list delete/undo unit: request
// mode codes, configuration register indexes, datapath operations and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cldu_pkg;

   // Default table size.
   localparam int DEF_MAX_ROWS = 1024;

   // Field widths fixed by the interface.
   localparam int MODE_W      = 3;
   localparam int STEPS_W     = 10;
   localparam int ROW_W       = 10;
   localparam int CURSOR_W    = 10;
   localparam int ROW_COUNT_W = 11;
   localparam int START_ROW_W = 10;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 11;

   // Configuration reset values.
   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 11'd8;
   localparam logic [START_ROW_W-1:0] START_ROW_RST = 10'd0;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW = 1'b1;

   // Request mode codes.
   typedef enum logic [MODE_W-1:0] {
      MODE_UP      = 3'd0,
      MODE_DOWN    = 3'd1,
      MODE_DELETE  = 3'd2,
      MODE_UNDO    = 3'd3,
      MODE_READ    = 3'd4,
      MODE_RESTART = 3'd5
   } mode_type;

   // Operations that the controller asks of the datapath, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_BUILD_INIT,
      OP_BUILD_STEP,
      OP_BUILD_END,
      OP_LINK_RD,
      OP_MOVE_STEP,
      OP_SET_ERR,
      OP_DEL_COMMIT,
      OP_POP,
      OP_UNDO_COMMIT,
      OP_FLAG_RD,
      OP_FINISH
   } dp_op_type;

   // Controller to datapath.
   typedef struct packed {
      dp_op_type op;
      logic      rd_popped;   // link read at the popped row instead of the cursor
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [MODE_W-1:0] req_mode;
      logic              steps_zero;
      logic              link_none;
      logic              del_blocked;
      logic              stack_empty;
      logic              build_last;
      logic              out_free;
   } status_type;

endpackage

>>> rtl/cldu_ctrl.sv
// ----------------------------------------------------------------------------
// cldu_ctrl
// Controller state machine. Sequences the table build, the link walk of a
// move, the unlink of a delete, the relink of an undo and the flag read, and
// hands one operation per cycle to the datapath.
// ----------------------------------------------------------------------------
module cldu_ctrl
   import cldu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [12:0] {
      ST_INIT      = 13'b0000000000001,
      ST_BUILD     = 13'b0000000000010,
      ST_BUILD_END = 13'b0000000000100,
      ST_IDLE      = 13'b0000000001000,
      ST_MOVE_RD   = 13'b0000000010000,
      ST_MOVE_CHK  = 13'b0000000100000,
      ST_DEL_RD    = 13'b0000001000000,
      ST_DEL_CHK   = 13'b0000010000000,
      ST_UNDO_RD   = 13'b0000100000000,
      ST_UNDO_LNK  = 13'b0001000000000,
      ST_UNDO_WR   = 13'b0010000000000,
      ST_READ_RD   = 13'b0100000000000,
      ST_FINISH    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      restart_resp_ff, restart_resp_in;

   // Requests are taken only between items.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and the operation for this cycle.
   always_comb begin
      state_in        = state_ff;
      restart_resp_in = restart_resp_ff;
      cmd.op          = OP_NONE;
      cmd.rd_popped   = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.op   = OP_BUILD_INIT;
            state_in = ST_BUILD;
         end
         ST_BUILD: begin
            cmd.op = OP_BUILD_STEP;
            if (status.build_last) begin
               state_in = ST_BUILD_END;
            end
         end
         ST_BUILD_END: begin
            cmd.op          = OP_BUILD_END;
            restart_resp_in = 1'b0;
            state_in        = restart_resp_ff ? ST_FINISH : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               case (mode_type'(status.req_mode))
                  MODE_UP, MODE_DOWN: state_in = ST_MOVE_RD;
                  MODE_DELETE:        state_in = ST_DEL_RD;
                  MODE_UNDO:          state_in = ST_UNDO_RD;
                  MODE_READ:          state_in = ST_READ_RD;
                  MODE_RESTART: begin
                     restart_resp_in = 1'b1;
                     state_in        = ST_INIT;
                  end
                  default:            state_in = ST_FINISH;
               endcase
            end
         end
         // Each link walked: read, then check and advance.
         ST_MOVE_RD: begin
            if (status.steps_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_LINK_RD;
               state_in = ST_MOVE_CHK;
            end
         end
         ST_MOVE_CHK: begin
            if (status.link_none) begin
               cmd.op   = OP_SET_ERR;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_MOVE_STEP;
               state_in = ST_MOVE_RD;
            end
         end
         ST_DEL_RD: begin
            cmd.op   = OP_LINK_RD;
            state_in = ST_DEL_CHK;
         end
         ST_DEL_CHK: begin
            cmd.op   = status.del_blocked ? OP_SET_ERR : OP_DEL_COMMIT;
            state_in = ST_FINISH;
         end
         ST_UNDO_RD: begin
            if (status.stack_empty) begin
               cmd.op   = OP_SET_ERR;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_POP;
               state_in = ST_UNDO_LNK;
            end
         end
         ST_UNDO_LNK: begin
            cmd.op        = OP_LINK_RD;
            cmd.rd_popped = 1'b1;
            state_in      = ST_UNDO_WR;
         end
         ST_UNDO_WR: begin
            cmd.op   = OP_UNDO_COMMIT;
            state_in = ST_FINISH;
         end
         ST_READ_RD: begin
            cmd.op   = OP_FLAG_RD;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // State registers; reset starts the table build.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         restart_resp_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         restart_resp_ff <= restart_resp_in;
      end
   end

endmodule

>>> rtl/cldu_dpath.sv
// ----------------------------------------------------------------------------
// cldu_dpath
// Datapath: configuration registers, the link, deleted-mark and undo stack
// memories, the cursor, the stack depth, the step counter and the response
// register. Executes one operation from the controller per cycle.
// ----------------------------------------------------------------------------
module cldu_dpath
   import cldu_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [STEPS_W-1:0]     req_steps,
   input  logic [ROW_W-1:0]       req_row,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CURSOR_W-1:0]    rsp_cursor,
   output logic                   rsp_row_deleted,
   output logic                   rsp_error,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  cmd_type                cmd,
   output status_type             status
);

   // Row index width, link width (holds the end marker) and row count width.
   localparam int IW = $clog2(MAX_ROWS);
   localparam int LW = IW + 1;
   localparam int NW = (LW > ROW_COUNT_W) ? LW : ROW_COUNT_W;
   localparam logic [LW-1:0] LINK_NONE = LW'(MAX_ROWS);

   // Memories.
   logic [LW-1:0] prev_mem  [MAX_ROWS];
   logic [LW-1:0] next_mem  [MAX_ROWS];
   logic          del_mem   [MAX_ROWS];
   logic [IW-1:0] stack_mem [MAX_ROWS];

   // Configuration registers.
   logic [ROW_COUNT_W-1:0] row_count_ff;
   logic [START_ROW_W-1:0] start_row_ff;

   // Item and working registers.
   logic [MODE_W-1:0]  mode_ff;
   logic [STEPS_W-1:0] steps_cnt_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [IW-1:0]      cursor_ff, cursor_in;
   logic [LW-1:0]      depth_ff, depth_in;
   logic               err_ff;
   logic [NW-1:0]      n_ff;
   logic [IW-1:0]      build_idx_ff;

   // Registered read data.
   logic [LW-1:0] prev_rdata_ff;
   logic [LW-1:0] next_rdata_ff;
   logic          del_rdata_ff;
   logic [IW-1:0] stack_rdata_ff;

   // Response register.
   logic                rsp_valid_ff;
   logic [CURSOR_W-1:0] rsp_cursor_ff;
   logic                rsp_row_deleted_ff;
   logic                rsp_error_ff;

   // Memory port controls.
   logic          link_re;
   logic [IW-1:0] link_raddr;
   logic          prev_we, next_we, del_we, stack_we, stack_re, del_re;
   logic [IW-1:0] prev_waddr, next_waddr, del_waddr, stack_waddr, stack_raddr;
   logic [LW-1:0] prev_wdata, next_wdata;
   logic          del_wdata;
   logic [IW-1:0] del_raddr;

   // Derived values.
   logic [NW-1:0]      rc_ext, n_in, idx_ext;
   logic [LW-1:0]      build_prev, build_next, walk_link;
   logic               prev_none, next_none, row_in_range, out_free;
   logic [ROW_COUNT_W-1:0] n_clamp_lo;

   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RST;
         start_row_ff <= START_ROW_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_wdata;
            CSR_START_ROW: start_row_ff <= csr_wdata[START_ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Row count saturated into the supported range.
   assign n_clamp_lo = (row_count_ff < ROW_COUNT_W'(2)) ? ROW_COUNT_W'(2) : row_count_ff;
   assign rc_ext     = NW'(n_clamp_lo);
   assign n_in       = (rc_ext > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : rc_ext;

   // Chain entry for the row being built.
   assign idx_ext    = NW'(build_idx_ff);
   assign build_prev = ((build_idx_ff == '0) || (idx_ext >= n_ff)) ?
                       LINK_NONE : (LW'(build_idx_ff) - LW'(1));
   assign build_next = ((idx_ext + NW'(1)) < n_ff) ? (LW'(build_idx_ff) + LW'(1)) : LINK_NONE;

   // Link checks on the registered read data.
   assign prev_none    = (prev_rdata_ff >= LINK_NONE);
   assign next_none    = (next_rdata_ff >= LINK_NONE);
   assign walk_link    = (mode_ff == MODE_UP) ? prev_rdata_ff : next_rdata_ff;
   assign row_in_range = (32'(row_ff) < MAX_ROWS);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Memory port selection for the current operation.
   always_comb begin
      link_re     = 1'b0;
      link_raddr  = cmd.rd_popped ? stack_rdata_ff : cursor_ff;
      prev_we     = 1'b0;
      prev_waddr  = prev_rdata_ff[IW-1:0];
      prev_wdata  = next_rdata_ff;
      next_we     = 1'b0;
      next_waddr  = next_rdata_ff[IW-1:0];
      next_wdata  = prev_rdata_ff;
      del_we      = 1'b0;
      del_waddr   = cursor_ff;
      del_wdata   = 1'b0;
      del_re      = 1'b0;
      del_raddr   = IW'(row_ff);
      stack_we    = 1'b0;
      stack_waddr = depth_ff[IW-1:0];
      stack_re    = 1'b0;
      stack_raddr = IW'(depth_ff - LW'(1));
      case (cmd.op)
         OP_BUILD_STEP: begin
            prev_we    = 1'b1;
            prev_waddr = build_idx_ff;
            prev_wdata = build_prev;
            next_we    = 1'b1;
            next_waddr = build_idx_ff;
            next_wdata = build_next;
            del_we     = 1'b1;
            del_waddr  = build_idx_ff;
         end
         OP_LINK_RD: begin
            link_re = 1'b1;
         end
         // Unlink the cursor row: its neighbors point past it.
         OP_DEL_COMMIT: begin
            next_we    = !prev_none;
            next_waddr = prev_rdata_ff[IW-1:0];
            next_wdata = next_rdata_ff;
            prev_we    = !next_none;
            prev_waddr = next_rdata_ff[IW-1:0];
            prev_wdata = prev_rdata_ff;
            del_we     = 1'b1;
            del_wdata  = 1'b1;
            stack_we   = 1'b1;
         end
         OP_POP: begin
            stack_re = 1'b1;
         end
         // Relink the popped row: its kept links still name its neighbors.
         OP_UNDO_COMMIT: begin
            next_we    = !prev_none;
            next_waddr = prev_rdata_ff[IW-1:0];
            next_wdata = LW'(stack_rdata_ff);
            prev_we    = !next_none;
            prev_waddr = next_rdata_ff[IW-1:0];
            prev_wdata = LW'(stack_rdata_ff);
            del_we     = 1'b1;
            del_waddr  = stack_rdata_ff;
         end
         OP_FLAG_RD: begin
            del_re = 1'b1;
         end
         default: ;
      endcase
   end

   // Link memories.
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (link_re) begin
         prev_rdata_ff <= prev_mem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (link_re) begin
         next_rdata_ff <= next_mem[link_raddr];
      end
   end

   // Deleted marks.
   always_ff @(posedge clock) begin
      if (del_we) begin
         del_mem[del_waddr] <= del_wdata;
      end
      if (del_re) begin
         del_rdata_ff <= del_mem[del_raddr];
      end
   end

   // Undo stack.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= cursor_ff;
      end
      if (stack_re) begin
         stack_rdata_ff <= stack_mem[stack_raddr];
      end
   end

   // Cursor and stack depth updates.
   always_comb begin
      cursor_in = cursor_ff;
      depth_in  = depth_ff;
      case (cmd.op)
         OP_BUILD_END: begin
            depth_in  = '0;
            cursor_in = (NW'(start_row_ff) < n_ff) ? IW'(start_row_ff) : IW'(n_ff - NW'(1));
         end
         OP_MOVE_STEP: begin
            cursor_in = walk_link[IW-1:0];
         end
         OP_DEL_COMMIT: begin
            depth_in  = depth_ff + LW'(1);
            cursor_in = next_none ? prev_rdata_ff[IW-1:0] : next_rdata_ff[IW-1:0];
         end
         OP_POP: begin
            depth_in = depth_ff - LW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // Item capture, step counter, error flag and build counter.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            mode_ff      <= req_mode;
            steps_cnt_ff <= req_steps;
            row_ff       <= req_row;
            err_ff       <= 1'b0;
         end
         OP_BUILD_INIT: begin
            n_ff         <= n_in;
            build_idx_ff <= '0;
         end
         OP_BUILD_STEP: begin
            build_idx_ff <= build_idx_ff + IW'(1);
         end
         OP_MOVE_STEP: begin
            steps_cnt_ff <= steps_cnt_ff - STEPS_W'(1);
         end
         OP_SET_ERR: begin
            err_ff <= 1'b1;
         end
         default: ;
      endcase
   end

   // Response register; a held response is replaced as it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_FINISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_FINISH) begin
         rsp_cursor_ff      <= CURSOR_W'(cursor_ff);
         rsp_row_deleted_ff <= (mode_ff == MODE_READ) && row_in_range && del_rdata_ff;
         rsp_error_ff       <= err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor      = rsp_cursor_ff;
   assign rsp_row_deleted = rsp_row_deleted_ff;
   assign rsp_error       = rsp_error_ff;

   // Status back to the controller.
   assign status.req_mode    = req_mode;
   assign status.steps_zero  = (steps_cnt_ff == '0);
   assign status.link_none   = (walk_link >= LINK_NONE);
   assign status.del_blocked = (prev_none && next_none) || (depth_ff >= LINK_NONE);
   assign status.stack_empty = (depth_ff == '0);
   assign status.build_last  = (build_idx_ff == IW'(MAX_ROWS - 1));
   assign status.out_free    = out_free;

   // A finished item always leaves a response behind.
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH |=> rsp_valid_ff)
      else $error("response not loaded after finish");

   // A pop takes exactly one entry off the stack.
   a_pop_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_POP |=> depth_ff == $past(depth_ff) - LW'(1))
      else $error("stack depth not decremented by pop");

   // Pops never run on an empty stack.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_POP |-> depth_ff != '0)
      else $error("pop from empty undo stack");

   // A delete only commits with room left on the stack.
   a_del_room: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DEL_COMMIT |-> depth_ff < LINK_NONE)
      else $error("delete committed with full undo stack");

endmodule

>>> rtl/cursor_list_delete_undo_unit.sv
// ----------------------------------------------------------------------------
// cursor_list_delete_undo_unit
// Cursor over a doubly linked list of rows with delete and undo. One request
// gives one response; the controller sequences the datapath memories.
// ----------------------------------------------------------------------------
// A move does one link read and one check per row walked. The next request
// can be accepted once the response is loaded, even while it still waits to
// be taken. Reset is synchronous; afterwards the link memories are rebuilt
// for the reset row count, one row per cycle, with req_stall high.
// Configuration writes are taken at any time.
module cursor_list_delete_undo_unit
   import cldu_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [STEPS_W-1:0]     req_steps,
   input  logic [ROW_W-1:0]       req_row,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CURSOR_W-1:0]    rsp_cursor,
   output logic                   rsp_row_deleted,
   output logic                   rsp_error,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   cldu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Memories, registers and response.
   cldu_dpath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_steps       (req_steps),
      .req_row         (req_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cursor      (rsp_cursor),
      .rsp_row_deleted (rsp_row_deleted),
      .rsp_error       (rsp_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

>>> verif/tb_cursor_list_delete_undo_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_list_delete_undo_unit
// Self-checking bench for the cursor list delete/undo unit. A queue-fed driver
// sends requests, a predictor keeps its own copy of the row list, the deleted
// marks and the undo stack, and a monitor checks each response in order.
// The run goes through several row count and start row settings.
// ----------------------------------------------------------------------------
module tb_cursor_list_delete_undo_unit;
   import cldu_pkg::*;

   localparam int TB_ROWS        = DEF_MAX_ROWS;
   localparam int LINK_NONE      = TB_ROWS;
   localparam int WATCHDOG_LIMIT = 10000;

   // Mode codes that the block ignores.
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [STEPS_W-1:0] steps;
      logic [ROW_W-1:0]   row;
   } req_item_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor;
      logic                row_deleted;
      logic                error;
   } rsp_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode = '0;
   logic [STEPS_W-1:0]    req_steps = '0;
   logic [ROW_W-1:0]      req_row = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CURSOR_W-1:0]   rsp_cursor;
   logic                  rsp_row_deleted;
   logic                  rsp_error;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predicted state of the block.
   logic [ROW_COUNT_W-1:0] prev_row [TB_ROWS];
   logic [ROW_COUNT_W-1:0] next_row [TB_ROWS];
   logic                   row_gone [TB_ROWS];
   logic [ROW_W-1:0]       undo_rows [TB_ROWS];
   int unsigned            undo_depth;
   logic [CURSOR_W-1:0]    cursor_pos;
   logic [ROW_COUNT_W-1:0] cfg_row_count;
   logic [START_ROW_W-1:0] cfg_start_row;

   req_item_type pending_reqs [$];
   rsp_item_type expected_rsp [$];
   req_item_type cur_req;
   int unsigned  idle_pct = 33;
   int unsigned  fail_count = 0;
   int unsigned  quiet_cycles = 0;

   cursor_list_delete_undo_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_steps       (req_steps),
      .req_row         (req_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cursor      (rsp_cursor),
      .rsp_row_deleted (rsp_row_deleted),
      .rsp_error       (rsp_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // Row count as the block uses it: saturated into [2, TB_ROWS].
   function automatic int unsigned clamp_rows(input int unsigned count);
      if (count < 2) return 2;
      if (count > TB_ROWS) return TB_ROWS;
      return count;
   endfunction

   // Rebuild the chain 0..n-1 from the current settings.
   function automatic void build_rows();
      int unsigned n;
      n = clamp_rows(32'(cfg_row_count));
      for (int i = 0; i < TB_ROWS; i++) begin
         prev_row[i] = ROW_COUNT_W'(LINK_NONE);
         next_row[i] = ROW_COUNT_W'(LINK_NONE);
         row_gone[i] = 1'b0;
      end
      for (int unsigned i = 0; i < n; i++) begin
         prev_row[i] = (i == 0) ? ROW_COUNT_W'(LINK_NONE) : ROW_COUNT_W'(i - 1);
         next_row[i] = (i + 1 == n) ? ROW_COUNT_W'(LINK_NONE) : ROW_COUNT_W'(i + 1);
      end
      undo_depth = 0;
      cursor_pos = (32'(cfg_start_row) < n) ? cfg_start_row : CURSOR_W'(n - 1);
   endfunction

   // Apply one request to the predicted list and return its response.
   function automatic rsp_item_type apply_request(input req_item_type rq);
      rsp_item_type r;
      int unsigned  c, p, nx, t;
      r = '0;
      c = 32'(cursor_pos);
      case (rq.mode)
         MODE_UP, MODE_DOWN: begin
            for (int unsigned i = 0; i < 32'(rq.steps); i++) begin
               nx = (rq.mode == MODE_UP) ? 32'(prev_row[c]) : 32'(next_row[c]);
               if (nx >= TB_ROWS) begin
                  r.error = 1'b1;
                  break;
               end
               c = nx;
            end
            cursor_pos = CURSOR_W'(c);
         end
         MODE_DELETE: begin
            p  = 32'(prev_row[c]);
            nx = 32'(next_row[c]);
            // The sole live row cannot be deleted; a full stack is guarded too.
            if ((p >= TB_ROWS && nx >= TB_ROWS) || undo_depth >= TB_ROWS) begin
               r.error = 1'b1;
            end else begin
               undo_rows[undo_depth] = ROW_W'(c);
               undo_depth++;
               row_gone[c] = 1'b1;
               if (p < TB_ROWS) next_row[p] = ROW_COUNT_W'(nx);
               if (nx < TB_ROWS) begin
                  prev_row[nx] = ROW_COUNT_W'(p);
                  cursor_pos = CURSOR_W'(nx);
               end else begin
                  cursor_pos = CURSOR_W'(p);
               end
            end
         end
         MODE_UNDO: begin
            if (undo_depth == 0) begin
               r.error = 1'b1;
            end else begin
               undo_depth--;
               t  = 32'(undo_rows[undo_depth]);
               p  = 32'(prev_row[t]);
               nx = 32'(next_row[t]);
               if (p < TB_ROWS) next_row[p] = ROW_COUNT_W'(t);
               if (nx < TB_ROWS) prev_row[nx] = ROW_COUNT_W'(t);
               row_gone[t] = 1'b0;
            end
         end
         MODE_READ: begin
            r.row_deleted = row_gone[rq.row];
         end
         MODE_RESTART: begin
            build_rows();
         end
         default: begin
         end
      endcase
      r.cursor = cursor_pos;
      return r;
   endfunction

   function automatic void queue_request(input logic [MODE_W-1:0] mode,
                                         input logic [STEPS_W-1:0] steps,
                                         input logic [ROW_W-1:0] row);
      req_item_type rq;
      rq.mode  = mode;
      rq.steps = steps;
      rq.row   = row;
      pending_reqs.insert(pending_reqs.size(), rq);
   endfunction

   // Random request for a list of n rows, weighted toward deletes and short moves.
   function automatic void queue_random(input int unsigned n);
      int unsigned        pick, sel;
      logic [MODE_W-1:0]  mode;
      logic [STEPS_W-1:0] steps;
      logic [ROW_W-1:0]   row;
      pick = $urandom_range(99);
      if (pick < 20) mode = MODE_UP;
      else if (pick < 40) mode = MODE_DOWN;
      else if (pick < 62) mode = MODE_DELETE;
      else if (pick < 77) mode = MODE_UNDO;
      else if (pick < 92) mode = MODE_READ;
      else if (pick < 95) mode = MODE_RESTART;
      else mode = ($urandom_range(1) != 0) ? MODE_SPARE_7 : MODE_SPARE_6;
      sel = $urandom_range(99);
      if (sel < 55) steps = STEPS_W'($urandom_range(0, 8));
      else if (sel < 88) steps = STEPS_W'($urandom_range(0, (n > 1023) ? 1023 : n));
      else steps = STEPS_W'($urandom_range(0, 1023));
      sel = $urandom_range(99);
      if (sel < 75) row = ROW_W'($urandom_range(0, n - 1));
      else row = ROW_W'($urandom_range(0, 1023));
      queue_request(mode, steps, row);
   endfunction

   // Driver: present the next queued request, hold it while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.insert(expected_rsp.size(), apply_request(cur_req));
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_mode  <= cur_req.mode;
               req_steps <= cur_req.steps;
               req_row   <= cur_req.row;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each taken response against the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_cursor !== want.cursor) begin
                  $error("cursor: expected %0d, got %0d", want.cursor, rsp_cursor);
                  fail_count++;
               end
               if (rsp_row_deleted !== want.row_deleted) begin
                  $error("row_deleted: expected %0d, got %0d", want.row_deleted,
                         rsp_row_deleted);
                  fail_count++;
               end
               if (rsp_error !== want.error) begin
                  $error("error: expected %0d, got %0d", want.error, rsp_error);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // Track register writes; they take effect at the next restart.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROW_COUNT: cfg_row_count = csr_wdata;
            CSR_START_ROW: cfg_start_row = csr_wdata[START_ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Watchdog on cycles in which no channel moves anything.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] reg_idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= reg_idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sender holds off until every request has been answered.
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] rc, sr;
      int unsigned           n;
      cfg_row_count = ROW_COUNT_RST;
      cfg_start_row = START_ROW_RST;
      build_rows();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests on the reset list of eight rows, cursor at the head.
      queue_request(MODE_READ, 10'd0, 10'd0);
      queue_request(MODE_UP, 10'd1, 10'd1023);        // past the head
      queue_request(MODE_DOWN, 10'd0, 10'd0);
      queue_request(MODE_DOWN, 10'd3, 10'd0);
      queue_request(MODE_DOWN, 10'd1023, 10'd0);      // past the tail
      queue_request(MODE_DELETE, 10'd0, 10'd0);       // tail: cursor goes back
      queue_request(MODE_READ, 10'd0, 10'd7);
      queue_request(MODE_READ, 10'd0, 10'd1023);      // beyond the row count
      queue_request(MODE_UP, 10'd2, 10'd0);
      queue_request(MODE_DELETE, 10'd0, 10'd0);
      queue_request(MODE_DELETE, 10'd0, 10'd0);
      queue_request(MODE_UNDO, 10'd0, 10'd0);
      queue_request(MODE_UNDO, 10'd0, 10'd0);
      queue_request(MODE_UNDO, 10'd0, 10'd0);
      queue_request(MODE_UNDO, 10'd0, 10'd0);         // empty stack
      queue_request(MODE_SPARE_6, 10'h3FF, 10'h3FF);
      queue_request(MODE_SPARE_7, 10'h155, 10'h2AA);
      queue_request(MODE_RESTART, 10'd0, 10'd0);
      wait_drained();

      // Row count below the minimum and start row beyond it: two rows, cursor at 1.
      write_csr(CSR_ROW_COUNT, 11'd1);
      write_csr(CSR_START_ROW, 11'd1023);
      queue_request(MODE_RESTART, 10'd0, 10'd0);
      queue_request(MODE_DELETE, 10'd0, 10'd0);
      queue_request(MODE_DELETE, 10'd0, 10'd0);       // sole live row
      queue_request(MODE_READ, 10'd0, 10'd1);
      queue_request(MODE_UNDO, 10'd0, 10'd0);
      queue_request(MODE_UP, 10'd1023, 10'd0);
      queue_request(MODE_DOWN, 10'd1023, 10'd0);
      repeat (80) queue_random(2);
      wait_drained();

      // Random phases, each under its own settings and started by a restart.
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: begin rc = 11'd2047; sr = 11'h7FF; end
            1: begin rc = 11'd0;    sr = 11'd0;   end
            2: begin rc = 11'd1024; sr = 11'd1023; end
            3: begin rc = 11'd5;    sr = 11'd4;   end
            4: begin rc = 11'd3;    sr = 11'd700; end
            5: begin rc = 11'd2;    sr = 11'd1;   end
            8: begin rc = 11'd1500; sr = 11'd512; end
            default: begin
               rc = CSR_DATA_W'($urandom_range(2, 48));
               if ($urandom_range(1) != 0) sr = CSR_DATA_W'($urandom_range(0, 32'(rc) - 1));
               else sr = CSR_DATA_W'($urandom_range(0, 2047));
            end
         endcase
         n = clamp_rows(32'(rc));
         // One full-size phase runs with no idling on either side.
         idle_pct = (ph == 2) ? 0 : 33;
         write_csr(CSR_ROW_COUNT, rc);
         write_csr(CSR_START_ROW, sr);
         queue_request(MODE_RESTART, STEPS_W'($urandom_range(0, 1023)),
                       ROW_W'($urandom_range(0, 1023)));
         repeat (110) queue_random(n);
         wait_drained();
      end

      // Let the block settle and catch any stray response.
      repeat (TB_ROWS + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
